### rtl/lrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrgb_pkg
// Shared widths, pipeline latency and the elaboration-time gamma table
// entry function for the linear RGB gamma encoder.
// ----------------------------------------------------------------------------
package lrgb_pkg;

    localparam int IN_W      = 20;
    localparam int OUT_W     = 32;
    localparam int CH_N      = 3;
    localparam int G_W       = 17;
    localparam int W_W       = 16;
    localparam int BIG_W     = 192;
    localparam int GAMMA_NUM = 5;
    localparam int GAMMA_DEN = 11;
    localparam int GAMMA_PREC = 16;
    localparam int LATENCY   = 5;
    localparam logic [7:0] ALPHA = 8'hFF;

    typedef logic [G_W-1:0] t_gamma;
    typedef logic [7:0]     t_byte;

    // floor(2^16 * (idx / 2^tbits)^(5/11)) by exact binary search
    function automatic t_gamma gamma_entry(input int unsigned idx,
                                           input int unsigned tbits);
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] pw;
        logic [G_W-1:0]   lo;
        logic [G_W-1:0]   hi;
        logic [G_W-1:0]   mid;
        logic [G_W:0]     sum;
        int               k;
        int               s;
        rhs = BIG_W'(1);
        for (k = 0; k < GAMMA_NUM; k++) begin
            rhs = rhs * BIG_W'(idx);
        end
        rhs = rhs << (GAMMA_DEN * GAMMA_PREC - GAMMA_NUM * int'(tbits));
        lo = '0;
        hi = G_W'(1) << GAMMA_PREC;
        for (s = 0; s < G_W + 1; s++) begin
            if (lo < hi) begin
                sum = (G_W + 1)'(lo) + (G_W + 1)'(hi) + (G_W + 1)'(1);
                mid = sum[G_W:1];
                pw  = BIG_W'(1);
                for (k = 0; k < GAMMA_DEN; k++) begin
                    pw = pw * BIG_W'(mid);
                end
                if (pw <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid - G_W'(1);
                end
            end
        end
        return lo;
    endfunction

endpackage

### rtl/linear_rgb_gamma_encode_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_rgb_gamma_encode_pack
// Linear RGB pixel to gamma 1/2.2 encoded ABGR8888 word, table with linear
// interpolation, five register stages.
// ----------------------------------------------------------------------------
// output: a word accepted at one edge appears on o_packed_pixel with o_strobe
//   after the five register stages, for exactly one cycle
// throughput: one word every cycle while busy is low; every channel stage is fully pipelined
// reset: synchronous, active low; clears all valid bits, busy is high only
//   while reset is held
// ----------------------------------------------------------------------------
module linear_rgb_gamma_encode_pack #(
    parameter int FRACTION_BITS    = 16,
    parameter int TABLE_INDEX_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [lrgb_pkg::IN_W-1:0]  i_red_linear,
    input  logic signed [lrgb_pkg::IN_W-1:0]  i_green_linear,
    input  logic signed [lrgb_pkg::IN_W-1:0]  i_blue_linear,
    output logic                              o_strobe,
    output logic [lrgb_pkg::OUT_W-1:0]        o_packed_pixel
);

    localparam int TB  = TABLE_INDEX_BITS;
    localparam int TS  = (1 << TB) + 1;
    localparam int IW  = TB + 1;
    localparam int QW  = TB + 17;
    localparam int XW  = (FRACTION_BITS + 1 > lrgb_pkg::IN_W) ?
                         FRACTION_BITS + 1 : lrgb_pkg::IN_W;
    localparam int SHW = XW + QW;
    localparam int PW  = lrgb_pkg::G_W + lrgb_pkg::W_W;
    localparam int YW  = lrgb_pkg::G_W + 8;
    localparam logic [XW-1:0] ONE = XW'(1) << FRACTION_BITS;

    // gamma table, built at elaboration
    lrgb_pkg::t_gamma w_lut [TS];

    for (genvar k = 0; k < TS; k++) begin : g_lut
        localparam lrgb_pkg::t_gamma ENTRY = lrgb_pkg::gamma_entry(k, TB);
        assign w_lut[k] = ENTRY;
    end

    logic                     accept;
    logic [lrgb_pkg::IN_W-1:0] w_raw [lrgb_pkg::CH_N];
    logic [XW-1:0]            w_x   [lrgb_pkg::CH_N];
    logic [SHW-1:0]           w_sh  [lrgb_pkg::CH_N];

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    assign w_raw[0] = $unsigned(i_red_linear);
    assign w_raw[1] = $unsigned(i_green_linear);
    assign w_raw[2] = $unsigned(i_blue_linear);

    // stage 1: clamp and table position
    logic                     r_v1, r_v2, r_v3, r_v4, r_strobe;
    logic [IW-1:0]            r_idx  [lrgb_pkg::CH_N];
    logic [lrgb_pkg::W_W-1:0] r_w1   [lrgb_pkg::CH_N];
    logic [lrgb_pkg::W_W-1:0] r_w2   [lrgb_pkg::CH_N];
    lrgb_pkg::t_gamma         r_a2   [lrgb_pkg::CH_N];
    lrgb_pkg::t_gamma         r_d2   [lrgb_pkg::CH_N];
    lrgb_pkg::t_gamma         r_a3   [lrgb_pkg::CH_N];
    lrgb_pkg::t_gamma         r_p3   [lrgb_pkg::CH_N];
    lrgb_pkg::t_gamma         r_g4   [lrgb_pkg::CH_N];
    logic [lrgb_pkg::OUT_W-1:0] r_pixel;

    for (genvar c = 0; c < lrgb_pkg::CH_N; c++) begin : g_ch
        logic [XW-1:0] w_xr;
        assign w_xr = XW'(w_raw[c]);
        always_comb begin
            if (w_raw[c][lrgb_pkg::IN_W-1]) begin
                w_x[c] = '0;
            end else if (w_xr > ONE) begin
                w_x[c] = ONE;
            end else begin
                w_x[c] = w_xr;
            end
        end
        if (TB + 16 >= FRACTION_BITS) begin : g_up
            assign w_sh[c] = {QW'(0), w_x[c]} << (TB + 16 - FRACTION_BITS);
        end else begin : g_dn
            assign w_sh[c] = {QW'(0), w_x[c]} >> (FRACTION_BITS - TB - 16);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < lrgb_pkg::CH_N; c++) begin
            r_idx[c] <= w_sh[c][QW-1:16];
            r_w1[c]  <= w_sh[c][15:0];
        end
    end

    // stage 2: table reads
    logic [IW-1:0] w_ib [lrgb_pkg::CH_N];

    always_comb begin
        for (int c = 0; c < lrgb_pkg::CH_N; c++) begin
            w_ib[c] = r_idx[c][TB] ? r_idx[c] : r_idx[c] + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < lrgb_pkg::CH_N; c++) begin
            r_a2[c] <= w_lut[r_idx[c]];
            r_d2[c] <= w_lut[w_ib[c]] - w_lut[r_idx[c]];
            r_w2[c] <= r_w1[c];
        end
    end

    // stage 3: slope times weight
    logic [PW-1:0] w_prod [lrgb_pkg::CH_N];

    always_comb begin
        for (int c = 0; c < lrgb_pkg::CH_N; c++) begin
            w_prod[c] = PW'(r_d2[c]) * PW'(r_w2[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < lrgb_pkg::CH_N; c++) begin
            r_a3[c] <= r_a2[c];
            r_p3[c] <= w_prod[c][PW-1:16];
        end
    end

    // stage 4: interpolated gamma value
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < lrgb_pkg::CH_N; c++) begin
            r_g4[c] <= r_a3[c] + r_p3[c];
        end
    end

    // stage 5: scale to a byte, round and pack
    logic [YW-1:0]   w_y  [lrgb_pkg::CH_N];
    lrgb_pkg::t_byte w_b  [lrgb_pkg::CH_N];

    always_comb begin
        for (int c = 0; c < lrgb_pkg::CH_N; c++) begin
            w_y[c] = (YW'(r_g4[c]) << 8) - YW'(r_g4[c]) + YW'(32768);
            w_b[c] = w_y[c][23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel <= {lrgb_pkg::ALPHA, w_b[2], w_b[1], w_b[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v1     <= accept;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            r_strobe <= r_v4;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_packed_pixel = r_pixel;

endmodule

### rtl/lrgb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrgb_checker
// Port-level checks of the gamma encoder: latency, alpha byte and the
// negative-input case.
// ----------------------------------------------------------------------------
module lrgb_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic signed [lrgb_pkg::IN_W-1:0]  i_red_linear,
    input logic signed [lrgb_pkg::IN_W-1:0]  i_green_linear,
    input logic signed [lrgb_pkg::IN_W-1:0]  i_blue_linear,
    input logic                              o_strobe,
    input logic [lrgb_pkg::OUT_W-1:0]        o_packed_pixel
);

    logic acc;
    logic all_neg;

    assign acc     = start && !busy;
    assign all_neg = i_red_linear[lrgb_pkg::IN_W-1] && i_green_linear[lrgb_pkg::IN_W-1]
                     && i_blue_linear[lrgb_pkg::IN_W-1];

    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##5 o_strobe)
        else $error("accepted word did not come out after five cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(acc, 5))
        else $error("strobe without a word accepted five cycles before");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_packed_pixel[31:24] == lrgb_pkg::ALPHA))
        else $error("alpha byte wrong");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && all_neg) |-> ##5 (o_packed_pixel == 32'hFF00_0000))
        else $error("negative channels did not give black");

endmodule

bind linear_rgb_gamma_encode_pack lrgb_checker u_lrgb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_red_linear   (i_red_linear),
    .i_green_linear (i_green_linear),
    .i_blue_linear  (i_blue_linear),
    .o_strobe       (o_strobe),
    .o_packed_pixel (o_packed_pixel)
);

### bench/gamma_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamma_pixel_checker
// Watches the pixel and packed-word channels of the gamma encoder, works out
// each packed word from its own interpolated 1/2.2 table and compares it with
// the word the block delivers, oldest first.
// ----------------------------------------------------------------------------
module gamma_pixel_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic signed [lrgb_pkg::IN_W-1:0] i_red_linear,
    input  logic signed [lrgb_pkg::IN_W-1:0] i_green_linear,
    input  logic signed [lrgb_pkg::IN_W-1:0] i_blue_linear,
    input  logic                             i_strobe,
    input  logic [lrgb_pkg::OUT_W-1:0]       i_packed_pixel,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam int FRAC_BITS  = 16;
    localparam int INDEX_BITS = 8;
    localparam int LUT_TOP    = 1 << INDEX_BITS;

    logic [16:0]              gamma_lut [0:LUT_TOP];
    logic [lrgb_pkg::OUT_W-1:0] expected_pixels [$];

    // largest r with r^11 <= idx^5 * 2^(176 - 5*INDEX_BITS), built bit by bit
    function automatic logic [16:0] gamma_point(input int unsigned idx);
        logic [199:0] target;
        logic [199:0] power;
        logic [16:0]  root;
        logic [16:0]  trial;
        int           b;
        int           k;
        target = 200'd1;
        for (k = 0; k < 5; k++) begin
            target = target * 200'(idx);
        end
        target = target << (11 * 16 - 5 * INDEX_BITS);
        root = '0;
        for (b = 16; b >= 0; b--) begin
            trial = root | (17'd1 << b);
            power = 200'd1;
            for (k = 0; k < 11; k++) begin
                power = power * 200'(trial);
            end
            if (power <= target) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic logic [7:0] encode_byte(input logic signed [lrgb_pkg::IN_W-1:0] raw);
        logic [63:0] level;
        logic [63:0] pos;
        logic [63:0] seg;
        logic [63:0] frac;
        logic [63:0] curve;
        logic [63:0] scaled;
        if (raw[lrgb_pkg::IN_W-1]) begin
            return 8'd0;
        end
        level = 64'(unsigned'(raw));
        if (level > (64'd1 << FRAC_BITS)) begin
            level = 64'd1 << FRAC_BITS;
        end
        pos  = (level << (INDEX_BITS + 16)) >> FRAC_BITS;
        seg  = pos >> 16;
        frac = pos & 64'hFFFF;
        if (seg >= 64'(LUT_TOP)) begin
            curve = 64'(gamma_lut[LUT_TOP]);
        end else begin
            curve = 64'(gamma_lut[seg]) +
                    (((64'(gamma_lut[seg + 1]) - 64'(gamma_lut[seg])) * frac) >> 16);
        end
        scaled = (curve * 64'd255 + 64'd32768) >> 16;
        return scaled[7:0];
    endfunction

    initial begin
        for (int i = 0; i <= LUT_TOP; i++) begin
            gamma_lut[i] = gamma_point(i);
        end
    end

    always @(posedge i_clk) begin
        logic [lrgb_pkg::OUT_W-1:0] want;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (expected_pixels.size() == 0) begin
                    $error("packed_pixel: word with nothing expected, actual %08h",
                           i_packed_pixel);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_packed_pixel !== want) begin
                        $error("packed_pixel mismatch: expected %08h, actual %08h",
                               want, i_packed_pixel);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_pixels.push_back({lrgb_pkg::ALPHA, encode_byte(i_blue_linear),
                                           encode_byte(i_green_linear),
                                           encode_byte(i_red_linear)});
            end
        end
        o_pending <= expected_pixels.size();
    end

endmodule

### bench/tb_linear_rgb_gamma_encode_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_rgb_gamma_encode_pack
// Drives linear RGB pixels into the gamma encoder, directed edge values first
// and then weighted random pixels with random gaps; a checker beside the
// block predicts every packed word and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_linear_rgb_gamma_encode_pack;

    localparam int RANDOM_PIXELS = 1000;
    localparam int STALL_LIMIT   = 1000;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    logic signed [lrgb_pkg::IN_W-1:0] i_red_linear;
    logic signed [lrgb_pkg::IN_W-1:0] i_green_linear;
    logic signed [lrgb_pkg::IN_W-1:0] i_blue_linear;
    logic                             o_strobe;
    logic [lrgb_pkg::OUT_W-1:0]       o_packed_pixel;

    int   fail_count;
    int   pending;
    int   quiet_cycles;
    logic took_word;
    bit   gaps_on;

    linear_rgb_gamma_encode_pack i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_red_linear   (i_red_linear),
        .i_green_linear (i_green_linear),
        .i_blue_linear  (i_blue_linear),
        .o_strobe       (o_strobe),
        .o_packed_pixel (o_packed_pixel)
    );

    gamma_pixel_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_red_linear   (i_red_linear),
        .i_green_linear (i_green_linear),
        .i_blue_linear  (i_blue_linear),
        .i_strobe       (o_strobe),
        .i_packed_pixel (o_packed_pixel),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        took_word <= i_rst_n && start && !busy;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // weighted towards the 0..1 range, with clamps, negatives and raw bit patterns
    function automatic logic signed [lrgb_pkg::IN_W-1:0] pick_channel();
        int unsigned roll;
        int          v;
        roll = $urandom_range(99);
        if (roll < 50) begin
            v = $urandom_range(0, 65536);
        end else if (roll < 58) begin
            v = $urandom_range(0, 600);
        end else if (roll < 66) begin
            v = 65532 + $urandom_range(0, 8);
        end else if (roll < 76) begin
            v = -int'($urandom_range(1, 524288));
        end else if (roll < 86) begin
            v = $urandom_range(65537, 524287);
        end else begin
            v = $urandom();
        end
        return v[lrgb_pkg::IN_W-1:0];
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_pixel(input logic signed [lrgb_pkg::IN_W-1:0] red,
                              input logic signed [lrgb_pkg::IN_W-1:0] green,
                              input logic signed [lrgb_pkg::IN_W-1:0] blue);
        while (gaps_on && $urandom_range(99) < 9) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start          <= 1'b1;
        i_red_linear   <= red;
        i_green_linear <= green;
        i_blue_linear  <= blue;
        do begin
            @(negedge i_clk);
        end while (!took_word);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_red_linear   = '0;
        i_green_linear = '0;
        i_blue_linear  = '0;
        gaps_on        = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero, one, clamps, sign extremes, table index edges
        send_pixel(20'sd0, 20'sd0, 20'sd0);
        send_pixel(20'sd65536, 20'sd65536, 20'sd65536);
        send_pixel(20'sd1, 20'sd1, 20'sd1);
        send_pixel(20'sh7FFFF, 20'sh80000, 20'shFFFFF);
        send_pixel(20'sh80000, 20'sh7FFFF, 20'sd1);
        send_pixel(20'sd65535, 20'sd65537, 20'sd0);
        send_pixel(20'sd255, 20'sd256, 20'sd257);
        send_pixel(20'sd32768, 20'sd16384, 20'sd49152);
        send_pixel(20'sd65280, 20'sd65281, 20'sd128);
        send_pixel(20'shFFFFF, 20'shFFFFF, 20'shFFFFF);
        send_pixel(20'sd131072, 20'shF0000, 20'sd65536);
        send_pixel(20'sd2, 20'sd3, 20'sd4);
        send_pixel(20'sd100, 20'sd1000, 20'sd10000);
        send_pixel(20'sh55555, 20'shAAAAA, 20'sh0FFFF);
        send_pixel(20'sh2AAAA, 20'sh05555, 20'sh10000);

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            gaps_on = !(n >= 300 && n < 550);
            if (n == 700) begin
                start <= 1'b0;
                do begin
                    @(negedge i_clk);
                end while (pending != 0);
            end
            send_pixel(pick_channel(), pick_channel(), pick_channel());
        end
        start <= 1'b0;

        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (lrgb_pkg::LATENCY + 3) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
rtl/lrgb_pkg.sv
rtl/linear_rgb_gamma_encode_pack.sv
rtl/lrgb_checker.sv
bench/gamma_pixel_checker.sv
bench/tb_linear_rgb_gamma_encode_pack.sv
